// File: rtl/tawa_pkg.sv
// Shared types, constants and the arctangent table of the tilt angle window averager.
// Used by the interfaces, the controller, the datapath and the top level.
`default_nettype none

package tawa_pkg;

    // Sample and result field widths
    localparam int SAMPLE_W = 16;
    localparam int PERIOD_W = 10;
    localparam int ANGLE_W  = 15;
    localparam int YAW_W    = 23;

    // Window length and accumulator widths
    localparam int WINDOW_SAMPLES = 10;
    localparam int COUNT_W        = 4;
    localparam int TILT_TOTAL_W   = 18;
    localparam int YAW_TOTAL_W    = 27;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 10'd100;

    // Iterative units
    localparam int SQRT_STEPS   = 24;
    localparam int CORDIC_STEPS = 24;
    localparam int STEP_W       = 5;
    localparam int SQRT_W       = 48;
    localparam int CORD_W       = 27;
    localparam int ZACC_W       = 32;

    // Angle scaling: hundredths of a degree times 65536
    localparam logic signed [ZACC_W-1:0] ANGLE_LIMIT = 32'sd589824000;
    localparam logic [13:0]              ANGLE_FULL  = 14'd9000;

    // Reciprocal division: floor(v / d) = (v * ceil(2^32 / d)) >> 32
    localparam int          RECIP_SHIFT = 32;
    localparam int          MUL_A_W     = 28;
    localparam int          MUL_B_W     = 33;
    localparam int          MUL_P_W     = MUL_A_W + MUL_B_W;
    localparam logic [63:0] YAW_DIVISOR = 64'd100;
    localparam logic [63:0] YAW_RECIP64 = ((64'd1 << RECIP_SHIFT) + YAW_DIVISOR - 64'd1)
                                          / YAW_DIVISOR;
    localparam logic [63:0] WIN_RECIP64 = ((64'd1 << RECIP_SHIFT) + 64'(WINDOW_SAMPLES)
                                          - 64'd1) / 64'(WINDOW_SAMPLES);
    localparam logic [MUL_B_W-1:0] YAW_RECIP = YAW_RECIP64[MUL_B_W-1:0];
    localparam logic [MUL_B_W-1:0] WIN_RECIP = WIN_RECIP64[MUL_B_W-1:0];
    localparam logic [MUL_A_W-1:0] YAW_HALF  = MUL_A_W'(YAW_DIVISOR / 64'd2);
    localparam logic [MUL_A_W-1:0] WIN_HALF  = MUL_A_W'(WINDOW_SAMPLES / 2);

    // atan(2^-i) in hundredths of a degree times 65536
    localparam logic [ZACC_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        32'd294912000, 32'd174096719, 32'd91987925, 32'd46694507, 32'd23437865,
        32'd11730358, 32'd5866610, 32'd2933484, 32'd1466764, 32'd733385,
        32'd366693, 32'd183346, 32'd91673, 32'd45837, 32'd22918,
        32'd11459, 32'd5730, 32'd2865, 32'd1432, 32'd716,
        32'd358, 32'd179, 32'd90, 32'd45
    };

    // Mean selector steps
    localparam logic [STEP_W-1:0] MEAN_ROLL  = 5'd0;
    localparam logic [STEP_W-1:0] MEAN_PITCH = 5'd1;
    localparam logic [STEP_W-1:0] MEAN_YAW   = 5'd2;

    // Datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_YAW_MUL,
        OP_YAW_DIV,
        OP_YAW_ACC,
        OP_SQ_A,
        OP_SQ_B,
        OP_SQRT,
        OP_CORD_INIT,
        OP_CORD,
        OP_ANGLE,
        OP_SUM,
        OP_MEAN_MUL,
        OP_MEAN_WR,
        OP_EMIT
    } tawa_op_t;

    typedef struct packed {
        tawa_op_t          op;
        logic              pitch;
        logic [STEP_W-1:0] step;
        logic              ready;
    } tawa_cmd_t;

    typedef struct packed {
        logic window_full;
        logic out_busy;
    } tawa_status_t;

endpackage

`default_nettype wire

// File: rtl/tawa_if.sv
// Channel interfaces of the tilt angle window averager: sample, result and configuration.
// Depends on tawa_pkg for field widths.
`default_nettype none

interface tawa_sample_if;
    import tawa_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] accel_x;
    logic signed [SAMPLE_W-1:0] accel_y;
    logic signed [SAMPLE_W-1:0] accel_z;
    logic signed [SAMPLE_W-1:0] gyro_z;
    modport source (output valid, accel_x, accel_y, accel_z, gyro_z, input ready);
    modport sink (input valid, accel_x, accel_y, accel_z, gyro_z, output ready);
endinterface

interface tawa_result_if;
    import tawa_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [ANGLE_W-1:0] roll_average;
    logic signed [ANGLE_W-1:0] pitch_average;
    logic signed [YAW_W-1:0]   yaw_average;
    modport source (output valid, roll_average, pitch_average, yaw_average, input ready);
    modport sink (input valid, roll_average, pitch_average, yaw_average, output ready);
endinterface

interface tawa_cfg_if;
    import tawa_pkg::*;
    logic                valid;
    logic                ready;
    logic [PERIOD_W-1:0] sample_period_ms;
    modport source (output valid, sample_period_ms, input ready);
    modport sink (input valid, sample_period_ms, output ready);
endinterface

`default_nettype wire

// File: rtl/tawa_ctrl.sv
// Sequencer of tilt angle window averager: steps the datapath per sample and window.
// Depends on tawa_pkg for the command and status types.
`default_nettype none

module tawa_ctrl (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   sample_valid,
    input  tawa_pkg::tawa_status_t status,
    output tawa_pkg::tawa_cmd_t   cmd
);
    import tawa_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_YAW_MUL,
        S_YAW_DIV,
        S_YAW_ACC,
        S_SQ_A,
        S_SQ_B,
        S_SQRT,
        S_CORD_INIT,
        S_CORD,
        S_ANGLE,
        S_SUM,
        S_CHECK,
        S_WAIT_OUT,
        S_MEAN_MUL,
        S_MEAN_WR,
        S_EMIT
    } state_t;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              pitch_reg, pitch_next;

    // Next state and step counter
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        pitch_next = pitch_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (sample_valid)
                begin
                    state_next = S_YAW_MUL;
                end
            end
            S_YAW_MUL:  state_next = S_YAW_DIV;
            S_YAW_DIV:  state_next = S_YAW_ACC;
            S_YAW_ACC:
            begin
                state_next = S_SQ_A;
                pitch_next = 1'b0;
            end
            S_SQ_A:     state_next = S_SQ_B;
            S_SQ_B:
            begin
                state_next = S_SQRT;
                step_next  = '0;
            end
            S_SQRT:
            begin
                if (step_reg == STEP_W'(SQRT_STEPS - 1))
                begin
                    state_next = S_CORD_INIT;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_CORD_INIT:
            begin
                state_next = S_CORD;
                step_next  = '0;
            end
            S_CORD:
            begin
                if (step_reg == STEP_W'(CORDIC_STEPS - 1))
                begin
                    state_next = S_ANGLE;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_ANGLE:
            begin
                if (pitch_reg)
                begin
                    state_next = S_SUM;
                end
                else
                begin
                    state_next = S_SQ_A;
                    pitch_next = 1'b1;
                end
            end
            S_SUM:      state_next = S_CHECK;
            S_CHECK:    state_next = status.window_full ? S_WAIT_OUT : S_IDLE;
            S_WAIT_OUT:
            begin
                if (!status.out_busy)
                begin
                    state_next = S_MEAN_MUL;
                    step_next  = MEAN_ROLL;
                end
            end
            S_MEAN_MUL: state_next = S_MEAN_WR;
            S_MEAN_WR:
            begin
                if (step_reg == MEAN_YAW)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_MEAN_MUL;
                    step_next  = step_reg + 1'b1;
                end
            end
            S_EMIT:     state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // Hold state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            pitch_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            pitch_reg <= pitch_next;
        end
    end

    // Decode commands
    always_comb
    begin
        cmd.pitch = pitch_reg;
        cmd.step  = step_reg;
        cmd.ready = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE:      cmd.op = sample_valid ? OP_LOAD : OP_NONE;
            S_YAW_MUL:   cmd.op = OP_YAW_MUL;
            S_YAW_DIV:   cmd.op = OP_YAW_DIV;
            S_YAW_ACC:   cmd.op = OP_YAW_ACC;
            S_SQ_A:      cmd.op = OP_SQ_A;
            S_SQ_B:      cmd.op = OP_SQ_B;
            S_SQRT:      cmd.op = OP_SQRT;
            S_CORD_INIT: cmd.op = OP_CORD_INIT;
            S_CORD:      cmd.op = OP_CORD;
            S_ANGLE:     cmd.op = OP_ANGLE;
            S_SUM:       cmd.op = OP_SUM;
            S_MEAN_MUL:  cmd.op = OP_MEAN_MUL;
            S_MEAN_WR:   cmd.op = OP_MEAN_WR;
            S_EMIT:      cmd.op = OP_EMIT;
            default:     cmd.op = OP_NONE;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/tawa_dp.sv
// Datapath of the tilt angle window averager: square root, CORDIC, yaw and window sums.
// Depends on tawa_pkg; driven by tawa_ctrl commands.
`default_nettype none

module tawa_dp (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  tawa_pkg::tawa_cmd_t                  cmd,
    output tawa_pkg::tawa_status_t               status,
    input  wire signed [tawa_pkg::SAMPLE_W-1:0]  accel_x,
    input  wire signed [tawa_pkg::SAMPLE_W-1:0]  accel_y,
    input  wire signed [tawa_pkg::SAMPLE_W-1:0]  accel_z,
    input  wire signed [tawa_pkg::SAMPLE_W-1:0]  gyro_z,
    input  wire                                  cfg_write,
    input  wire        [tawa_pkg::PERIOD_W-1:0]  cfg_period,
    input  wire                                  out_ready,
    output logic                                 out_valid,
    output logic signed [tawa_pkg::ANGLE_W-1:0]  roll_average,
    output logic signed [tawa_pkg::ANGLE_W-1:0]  pitch_average,
    output logic signed [tawa_pkg::YAW_W-1:0]    yaw_average
);
    import tawa_pkg::*;

    // Configuration and sample registers
    logic        [PERIOD_W-1:0] period_reg;
    logic signed [SAMPLE_W-1:0] ax_reg, ay_reg, az_reg, gz_reg;

    // Arithmetic working registers
    logic signed [26:0]          prod_reg;
    logic [MUL_P_W-1:0]          mul_reg;
    logic                        neg_reg;
    logic [31:0]                 d2_reg;
    logic [SQRT_W-1:0]           rem_reg, root_reg;
    logic signed [CORD_W-1:0]    x_reg, y_reg;
    logic signed [ZACC_W-1:0]    z_reg;
    logic signed [ANGLE_W-1:0]   roll_reg, pitch_reg;

    // Window state
    logic [COUNT_W-1:0]             count_reg;
    logic signed [TILT_TOTAL_W-1:0] roll_total_reg, pitch_total_reg;
    logic signed [YAW_W-1:0]        yaw_running_reg;
    logic signed [YAW_TOTAL_W-1:0]  yaw_total_reg;

    // Result register
    logic                        out_valid_reg;
    logic signed [ANGLE_W-1:0]   roll_out_reg, pitch_out_reg;
    logic signed [YAW_W-1:0]     yaw_out_reg;

    // Combinational helpers
    logic signed [SAMPLE_W-1:0] sq_sel;
    logic signed [31:0]         sq_val;
    logic signed [16:0]         num_wide;
    logic [16:0]                mag;
    logic                       ang_neg;
    logic [SQRT_W-1:0]          sq_v, sq_r, sq_bit, sq_trial;
    logic signed [CORD_W-1:0]   dx, dy;
    logic signed [ZACC_W-1:0]   tab_val, z_clamp, z_round;
    logic [13:0]                ang_mag;
    logic signed [ANGLE_W-1:0]  ang_val;
    logic [25:0]                yaw_mag;
    logic signed [YAW_TOTAL_W-1:0] mean_src;
    logic [YAW_TOTAL_W-1:0]     mean_mag;
    logic [MUL_A_W-1:0]         mul_a;
    logic [MUL_B_W-1:0]         mul_b;
    logic [MUL_P_W-RECIP_SHIFT-1:0] quot;
    logic signed [MUL_P_W-RECIP_SHIFT:0] quot_s;
    logic signed [YAW_W:0]      yaw_sum;
    logic signed [TILT_TOTAL_W:0] roll_grown, pitch_grown;
    logic signed [YAW_TOTAL_W:0]  yawt_sum;

    // Select square operand and tilt numerator
    always_comb
    begin
        sq_sel   = (cmd.op == OP_SQ_A) ? (cmd.pitch ? ay_reg : ax_reg) : az_reg;
        sq_val   = sq_sel * sq_sel;
        num_wide = cmd.pitch ? 17'(ax_reg) : 17'(ay_reg);
        mag      = num_wide[16] ? 17'(-num_wide) : 17'(num_wide);
        ang_neg  = cmd.pitch ? (!ax_reg[SAMPLE_W-1] && (ax_reg != '0)) : ay_reg[SAMPLE_W-1];
    end

    // One bit of the floor square root per step
    always_comb
    begin
        sq_v     = (cmd.step == '0) ? {d2_reg, 16'b0} : rem_reg;
        sq_r     = (cmd.step == '0) ? '0 : root_reg;
        sq_bit   = SQRT_W'(1) << (6'(SQRT_W - 2) - {cmd.step, 1'b0});
        sq_trial = sq_r + sq_bit;
    end

    // CORDIC shifts and angle finish
    always_comb
    begin
        dx      = y_reg >>> cmd.step;
        dy      = x_reg >>> cmd.step;
        tab_val = signed'(ATAN_TAB[cmd.step]);
        if (z_reg < 0)
        begin
            z_clamp = '0;
        end
        else if (z_reg > ANGLE_LIMIT)
        begin
            z_clamp = ANGLE_LIMIT;
        end
        else
        begin
            z_clamp = z_reg;
        end
        z_round = z_clamp + 32'sd32768;
        if (d2_reg == '0)
        begin
            ang_mag = (mag == '0) ? 14'd0 : ANGLE_FULL;
        end
        else
        begin
            ang_mag = z_round[29:16];
        end
        ang_val = ang_neg ? -ANGLE_W'(ang_mag) : ANGLE_W'(ang_mag);
    end

    // Shared reciprocal multiplier operands
    always_comb
    begin
        yaw_mag = prod_reg[26] ? 26'(-prod_reg) : 26'(prod_reg);
        case (cmd.step)
            MEAN_ROLL:  mean_src = YAW_TOTAL_W'(roll_total_reg);
            MEAN_PITCH: mean_src = YAW_TOTAL_W'(pitch_total_reg);
            default:    mean_src = yaw_total_reg;
        endcase
        mean_mag = mean_src[YAW_TOTAL_W-1] ? YAW_TOTAL_W'(-mean_src) : YAW_TOTAL_W'(mean_src);
        if (cmd.op == OP_YAW_DIV)
        begin
            mul_a = MUL_A_W'(yaw_mag) + YAW_HALF;
            mul_b = YAW_RECIP;
        end
        else
        begin
            mul_a = MUL_A_W'(mean_mag) + WIN_HALF;
            mul_b = WIN_RECIP;
        end
        quot   = mul_reg[MUL_P_W-1:RECIP_SHIFT];
        quot_s = neg_reg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    end

    // Widened sums for the saturating updates
    always_comb
    begin
        yaw_sum     = (YAW_W+1)'(yaw_running_reg) + (YAW_W+1)'(quot_s);
        roll_grown  = (TILT_TOTAL_W+1)'(roll_total_reg) + (TILT_TOTAL_W+1)'(roll_reg);
        pitch_grown = (TILT_TOTAL_W+1)'(pitch_total_reg) + (TILT_TOTAL_W+1)'(pitch_reg);
        yawt_sum    = (YAW_TOTAL_W+1)'(yaw_total_reg) + (YAW_TOTAL_W+1)'(yaw_running_reg);
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                ax_reg <= accel_x;
                ay_reg <= accel_y;
                az_reg <= accel_z;
                gz_reg <= gyro_z;
            end
            OP_YAW_MUL:
            begin
                prod_reg <= 27'(gz_reg) * $signed({17'b0, period_reg});
            end
            OP_YAW_DIV:
            begin
                neg_reg <= prod_reg[26];
                mul_reg <= MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
            end
            OP_SQ_A:
            begin
                d2_reg <= 32'(sq_val);
            end
            OP_SQ_B:
            begin
                d2_reg <= d2_reg + 32'(sq_val);
            end
            OP_SQRT:
            begin
                if (sq_v >= sq_trial)
                begin
                    rem_reg  <= sq_v - sq_trial;
                    root_reg <= (sq_r >> 1) + sq_bit;
                end
                else
                begin
                    rem_reg  <= sq_v;
                    root_reg <= sq_r >> 1;
                end
            end
            OP_CORD_INIT:
            begin
                x_reg <= CORD_W'(root_reg[23:0]);
                y_reg <= CORD_W'({mag, 8'b0});
                z_reg <= '0;
            end
            OP_CORD:
            begin
                if (y_reg > 0)
                begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + tab_val;
                end
                else
                begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - tab_val;
                end
            end
            OP_ANGLE:
            begin
                if (cmd.pitch)
                begin
                    pitch_reg <= ang_val;
                end
                else
                begin
                    roll_reg <= ang_val;
                end
            end
            OP_MEAN_MUL:
            begin
                neg_reg <= mean_src[YAW_TOTAL_W-1];
                mul_reg <= MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
            end
            OP_MEAN_WR:
            begin
                case (cmd.step)
                    MEAN_ROLL:  roll_out_reg  <= ANGLE_W'(quot_s);
                    MEAN_PITCH: pitch_out_reg <= ANGLE_W'(quot_s);
                    default:    yaw_out_reg   <= YAW_W'(quot_s);
                endcase
            end
            default:
            begin
            end
        endcase
    end

    // Window state, configuration and result handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg      <= PERIOD_RESET;
            count_reg       <= '0;
            roll_total_reg  <= '0;
            pitch_total_reg <= '0;
            yaw_running_reg <= '0;
            yaw_total_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                period_reg <= cfg_period;
            end
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (cmd.op)
                OP_YAW_ACC:
                begin
                    if (yaw_sum > (YAW_W+1)'(4194303))
                    begin
                        yaw_running_reg <= YAW_W'(4194303);
                    end
                    else if (yaw_sum < -(YAW_W+1)'(4194304))
                    begin
                        yaw_running_reg <= YAW_W'(-4194304);
                    end
                    else
                    begin
                        yaw_running_reg <= YAW_W'(yaw_sum);
                    end
                end
                OP_SUM:
                begin
                    count_reg <= count_reg + 1'b1;
                    if (roll_grown > (TILT_TOTAL_W+1)'(131071))
                    begin
                        roll_total_reg <= TILT_TOTAL_W'(131071);
                    end
                    else if (roll_grown < -(TILT_TOTAL_W+1)'(131072))
                    begin
                        roll_total_reg <= TILT_TOTAL_W'(-131072);
                    end
                    else
                    begin
                        roll_total_reg <= TILT_TOTAL_W'(roll_grown);
                    end
                    if (pitch_grown > (TILT_TOTAL_W+1)'(131071))
                    begin
                        pitch_total_reg <= TILT_TOTAL_W'(131071);
                    end
                    else if (pitch_grown < -(TILT_TOTAL_W+1)'(131072))
                    begin
                        pitch_total_reg <= TILT_TOTAL_W'(-131072);
                    end
                    else
                    begin
                        pitch_total_reg <= TILT_TOTAL_W'(pitch_grown);
                    end
                    if (yawt_sum > (YAW_TOTAL_W+1)'(67108863))
                    begin
                        yaw_total_reg <= YAW_TOTAL_W'(67108863);
                    end
                    else if (yawt_sum < -(YAW_TOTAL_W+1)'(67108864))
                    begin
                        yaw_total_reg <= YAW_TOTAL_W'(-67108864);
                    end
                    else
                    begin
                        yaw_total_reg <= YAW_TOTAL_W'(yawt_sum);
                    end
                end
                OP_EMIT:
                begin
                    out_valid_reg   <= 1'b1;
                    count_reg       <= '0;
                    roll_total_reg  <= '0;
                    pitch_total_reg <= '0;
                    yaw_running_reg <= '0;
                    yaw_total_reg   <= '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign status.window_full = (count_reg >= COUNT_W'(WINDOW_SAMPLES));
    assign status.out_busy    = out_valid_reg;
    assign out_valid          = out_valid_reg;
    assign roll_average       = roll_out_reg;
    assign pitch_average      = pitch_out_reg;
    assign yaw_average        = yaw_out_reg;

endmodule

`default_nettype wire

// File: rtl/tilt_angle_window_averager.sv
// Tilt angle window averager: a sample runs the yaw update and two passes of the
// 24-step square root and the 24-step CORDIC on the shared datapath before the next
// sample is accepted. A window result follows its last sample through the check, a wait
// for a free output register, the three mean steps and the emit, and waits in that register.
// Reset clears all sums, the sample count and the result valid; the period resets to 100.
`default_nettype none

module tilt_angle_window_averager (
    input wire           clk,
    input wire           rst_n,
    tawa_sample_if.sink  sample,
    tawa_result_if.source result,
    tawa_cfg_if.sink     cfg
);
    import tawa_pkg::*;

    tawa_cmd_t    cmd;
    tawa_status_t status;

    // Sequence the datapath
    tawa_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample.valid),
        .status       (status),
        .cmd          (cmd)
    );

    tawa_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .accel_x       (sample.accel_x),
        .accel_y       (sample.accel_y),
        .accel_z       (sample.accel_z),
        .gyro_z        (sample.gyro_z),
        .cfg_write     (cfg.valid),
        .cfg_period    (cfg.sample_period_ms),
        .out_ready     (result.ready),
        .out_valid     (result.valid),
        .roll_average  (result.roll_average),
        .pitch_average (result.pitch_average),
        .yaw_average   (result.yaw_average)
    );

    // Take samples only between sequences; configuration is always taken
    assign sample.ready = cmd.ready;
    assign cfg.ready    = 1'b1;

endmodule

`default_nettype wire

// File: rtl/tawa_checker.sv
// Port-level checks of the tilt angle window averager, attached by bind.
// Depends only on the top level's ports.
`default_nettype none

module tawa_checker (
    input wire               clk,
    input wire               rst_n,
    input wire               in_valid,
    input wire               in_ready,
    input wire               out_valid,
    input wire               out_ready,
    input wire signed [14:0] roll_average,
    input wire signed [14:0] pitch_average,
    input wire signed [22:0] yaw_average
);

    // A stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(roll_average)
            && $stable(pitch_average) && $stable(yaw_average))
        else $error("stalled result changed");

    // Averaged angles stay within a quarter turn
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> roll_average <= 15'sd9000 && roll_average >= -15'sd9000)
        else $error("roll average out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pitch_average <= 15'sd9000 && pitch_average >= -15'sd9000)
        else $error("pitch average out of range");

    // A taken sample keeps the block busy for the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("sample taken while busy");

    // Results are a window apart: none directly after one is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=> !out_valid)
        else $error("result repeated");

endmodule

bind tilt_angle_window_averager tawa_checker u_tawa_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (sample.valid),
    .in_ready      (sample.ready),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .roll_average  (result.roll_average),
    .pitch_average (result.pitch_average),
    .yaw_average   (result.yaw_average)
);

`default_nettype wire

// File: tb/sv/tilt_angle_window_averager_test.sv
// Self-checking testbench of the tilt angle window averager: drives samples, checks window means.
// Depends on tawa_pkg and the channel interfaces in tawa_if; the predictor is built in.
`default_nettype none

module tilt_angle_window_averager_test;
    timeunit 1ns;
    timeprecision 1ps;
    import tawa_pkg::*;

    localparam int  SETTLE_CYCLES = 300;
    localparam longint CYCLE_LIMIT = 1000000;
    localparam int  PHASE_ITEMS   = 100;
    localparam longint HOLD_START = 20000;
    localparam longint HOLD_END   = 26000;

    typedef struct {
        logic signed [SAMPLE_W-1:0] ax;
        logic signed [SAMPLE_W-1:0] ay;
        logic signed [SAMPLE_W-1:0] az;
        logic signed [SAMPLE_W-1:0] gz;
    } sample_t;

    typedef struct {
        logic signed [ANGLE_W-1:0] roll;
        logic signed [ANGLE_W-1:0] pitch;
        logic signed [YAW_W-1:0]   yaw;
    } means_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    tawa_sample_if sample_ch ();
    tawa_result_if result_ch ();
    tawa_cfg_if    cfg_ch ();

    tilt_angle_window_averager dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    sample_t samples_pending[$];
    means_t  means_expected[$];
    sample_t sample_on_bus;
    int      errors = 0;
    int      samples_taken = 0;
    int      windows_seen = 0;
    int      periods_written = 0;
    longint  cycle_count = 0;

    // Predictor state
    longint unsigned period_ms = PERIOD_RESET;
    int     window_count = 0;
    longint roll_acc = 0;
    longint pitch_acc = 0;
    longint yaw_now = 0;
    longint yaw_sum = 0;

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint round_div(longint v, longint d);
        longint m;
        longint q;
        m = v < 0 ? -v : v;
        q = (m + d / 2) / d;
        return v < 0 ? -q : q;
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v = v - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // Vectoring CORDIC on (sqrt(a^2+b^2), |num|), sign of num applied last
    function automatic longint tilt_angle(longint num, longint a, longint b);
        longint unsigned d2;
        longint unsigned mag;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        longint ang;
        d2 = longint'(a * a) + longint'(b * b);
        mag = num < 0 ? -num : num;
        if (d2 == 0)
            return mag == 0 ? 0 : (num < 0 ? -9000 : 9000);
        x = longint'(floor_sqrt(d2 << 16));
        y = longint'(mag << 8);
        z = 0;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0)
            begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(ATAN_TAB[i]);
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(ATAN_TAB[i]);
            end
        end
        z = clamp(z, 0, longint'(ANGLE_FULL) * 65536);
        ang = (z + 32768) >>> 16;
        return num < 0 ? -ang : ang;
    endfunction

    // Fold one accepted sample into the window; queue the means when it closes
    task automatic accumulate_sample(sample_t s);
        longint ax;
        longint ay;
        longint az;
        longint gz;
        means_t m;
        ax = s.ax;
        ay = s.ay;
        az = s.az;
        gz = s.gz;
        yaw_now = clamp(yaw_now + round_div(gz * longint'(period_ms), 100), -4194304, 4194303);
        roll_acc = clamp(roll_acc + tilt_angle(ay, ax, az), -131072, 131071);
        pitch_acc = clamp(pitch_acc + tilt_angle(-ax, ay, az), -131072, 131071);
        yaw_sum = clamp(yaw_sum + yaw_now, -67108864, 67108863);
        window_count++;
        if (window_count == WINDOW_SAMPLES)
        begin
            m.roll = ANGLE_W'(round_div(roll_acc, WINDOW_SAMPLES));
            m.pitch = ANGLE_W'(round_div(pitch_acc, WINDOW_SAMPLES));
            m.yaw = YAW_W'(round_div(yaw_sum, WINDOW_SAMPLES));
            means_expected.push_back(m);
            window_count = 0;
            roll_acc = 0;
            pitch_acc = 0;
            yaw_now = 0;
            yaw_sum = 0;
        end
    endtask

    // Mostly back-to-back, sometimes short gaps, rarely long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(150, 20);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] random_axis();
        int r;
        r = $urandom_range(99);
        if (r < 70) return SAMPLE_W'($urandom);
        if (r < 85) return SAMPLE_W'($urandom_range(80) - 40);
        if (r < 92) return 16'sh8000;
        return 16'sd0;
    endfunction

    function automatic sample_t make_sample(int ax, int ay, int az, int gz);
        sample_t s;
        s.ax = SAMPLE_W'(ax);
        s.ay = SAMPLE_W'(ay);
        s.az = SAMPLE_W'(az);
        s.gz = SAMPLE_W'(gz);
        return s;
    endfunction

    // Sample driver: advance on each accepted beat
    int send_gap = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (sample_ch.valid && sample_ch.ready)
            begin
                accumulate_sample(sample_on_bus);
                samples_taken++;
            end
            if (!sample_ch.valid || sample_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    sample_ch.valid <= 1'b0;
                end
                else if (samples_pending.size() > 0)
                begin
                    sample_on_bus = samples_pending.pop_front();
                    sample_ch.accel_x <= sample_on_bus.ax;
                    sample_ch.accel_y <= sample_on_bus.ay;
                    sample_ch.accel_z <= sample_on_bus.az;
                    sample_ch.gyro_z <= sample_on_bus.gz;
                    sample_ch.valid <= 1'b1;
                    send_gap = pick_gap();
                end
                else
                    sample_ch.valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls plus one long hold-off
    int  recv_gap = 0;
    logic hold_off = 1'b0;
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        hold_off <= (cycle_count >= HOLD_START) && (cycle_count < HOLD_END);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_off)
                result_ch.ready <= 1'b0;
            else if (recv_gap > 0)
            begin
                recv_gap--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= 1'b1;
                recv_gap = pick_gap();
            end
        end
    end

    // Result checker: compare each accepted beat with the oldest expectation
    always @(posedge clk)
    begin
        means_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            windows_seen++;
            if (means_expected.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result roll=%0d pitch=%0d yaw=%0d", $realtime,
                         result_ch.roll_average, result_ch.pitch_average,
                         result_ch.yaw_average);
            end
            else
            begin
                want = means_expected.pop_front();
                if (result_ch.roll_average !== want.roll)
                begin
                    errors++;
                    $display("%0t: roll_average expected %0d got %0d", $realtime,
                             want.roll, result_ch.roll_average);
                end
                if (result_ch.pitch_average !== want.pitch)
                begin
                    errors++;
                    $display("%0t: pitch_average expected %0d got %0d", $realtime,
                             want.pitch, result_ch.pitch_average);
                end
                if (result_ch.yaw_average !== want.yaw)
                begin
                    errors++;
                    $display("%0t: yaw_average expected %0d got %0d", $realtime,
                             want.yaw, result_ch.yaw_average);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $realtime,
                     means_expected.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Write the period register; the block must be idle
    task automatic write_period(logic [PERIOD_W-1:0] value);
        @(posedge clk);
        cfg_ch.sample_period_ms <= value;
        cfg_ch.valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        period_ms = value;
        periods_written++;
        cfg_ch.valid <= 1'b0;
    endtask

    // Hold until every queued sample and every expected window is through
    task automatic drain();
        while (samples_pending.size() > 0 || sample_ch.valid || means_expected.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    logic [PERIOD_W-1:0] period_plan[$];

    initial
    begin
        sample_ch.valid = 1'b0;
        sample_ch.accel_x = '0;
        sample_ch.accel_y = '0;
        sample_ch.accel_z = '0;
        sample_ch.gyro_z = '0;
        result_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.sample_period_ms = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: zero denominators, full-scale axes and rates, reset period
        samples_pending.push_back(make_sample(0, 0, 0, 0));
        samples_pending.push_back(make_sample(0, -32768, 0, 32767));
        samples_pending.push_back(make_sample(0, 32767, 0, -32768));
        samples_pending.push_back(make_sample(-32768, 0, 0, 32767));
        samples_pending.push_back(make_sample(32767, 0, 0, -32768));
        samples_pending.push_back(make_sample(-32768, -32768, -32768, 32767));
        samples_pending.push_back(make_sample(32767, 32767, 32767, 32767));
        samples_pending.push_back(make_sample(0, 0, 16384, 1));
        samples_pending.push_back(make_sample(1, -1, 1, -1));
        samples_pending.push_back(make_sample(-32768, 32767, -32768, -32768));
        samples_pending.push_back(make_sample(100, 100, 0, 50));
        samples_pending.push_back(make_sample(0, 0, -32768, -50));
        samples_pending.push_back(make_sample(32767, -32768, 1, 32767));
        samples_pending.push_back(make_sample(-1, 0, 0, 32767));
        samples_pending.push_back(make_sample(0, 1, 0, 32767));
        samples_pending.push_back(make_sample(5, 3, -4, 32767));
        samples_pending.push_back(make_sample(-32768, 0, -32768, 32767));
        samples_pending.push_back(make_sample(0, -32768, 32767, 32767));
        samples_pending.push_back(make_sample(2, 2, 2, -32768));
        samples_pending.push_back(make_sample(-16384, 16384, 0, -32768));
        drain();

        // Random phases across extreme and ordinary periods, 0 freezing yaw
        period_plan = '{10'd1000, 10'd0, 10'd1, 10'd1023,
                        PERIOD_W'($urandom_range(1000, 1)), 10'd100};
        foreach (period_plan[p])
        begin
            write_period(period_plan[p]);
            for (int n = 0; n < PHASE_ITEMS; n++)
                samples_pending.push_back(make_sample(random_axis(), random_axis(),
                                                      random_axis(),
                                                      int'(SAMPLE_W'($urandom))));
            drain();
        end

        $display("Ran %0d samples over %0d period settings; %0d window results checked.",
                 samples_taken, periods_written + 1, windows_seen);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
rtl/tawa_pkg.sv
rtl/tawa_if.sv
rtl/tawa_ctrl.sv
rtl/tawa_dp.sv
rtl/tilt_angle_window_averager.sv
rtl/tawa_checker.sv
tb/sv/tilt_angle_window_averager_test.sv
